/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// Shared helpers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/gso_pkg.sv */
// ----------------------------------------------------------------------------
// gso_pkg
// Widths and helpers for the Gram-Schmidt orthonormalisation core.
// ----------------------------------------------------------------------------
package gso_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = 6;
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 16;
    localparam int MAG_W   = 17;
    localparam int PROD_W  = 34;
    localparam int ACC_W   = 40;
    localparam int SUMSQ_W = 37;
    localparam int LEN_W   = 19;
    localparam int DIVD_W  = 31;
    localparam int FRAC_W  = 14;

    // magnitude of a signed 16-bit value, 17 bits wide
    function automatic logic [MAG_W-1:0] mag16(input logic [DATA_W-1:0] v);
        logic [MAG_W-1:0] e;
        e = {v[DATA_W-1], v};
        return v[DATA_W-1] ? (~e + MAG_W'(1)) : e;
    endfunction

endpackage

/* src/gram_schmidt_orthonormalize_core.sv */
// Sequence: a non-final pair keeps busy high through the bit-serial 17-bit multiply and
// the accumulate; the final pair adds the inner product, a residual pass per element,
// the square root and, per element, the serial divide (skipped when the length is
// zero) and the result output.
// Throughput: one vector at a time, set by the bit-serial multiplier and divider.
// Reset clears control state, the count, the accumulator and the output registers; stores are not cleared.
// ----------------------------------------------------------------------------
// gram_schmidt_orthonormalize_core
// Stores a vector pair, removes the reference projection and normalises the
// residual using bit-serial multiply, square root and divide units.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gram_schmidt_orthonormalize_core
    import gso_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] reference_value,
    input  logic signed [DATA_W-1:0] target_value,
    input  logic                     last_in,
    output logic                     valid,
    output logic signed [DATA_W-1:0] result_value,
    output logic                     last_out,
    output logic                     degenerate
);

    typedef enum logic [3:0] {
        S_IDLE, S_LMUL, S_LACC, S_IP, S_RRD, S_RSET, S_RMUL1, S_RSUB,
        S_RMUL2, S_RACC, S_SQRT, S_DRD, S_DSET, S_DIV, S_DOUT
    } state_t;

    state_t state_reg;

    // vector stores
    logic [DATA_W-1:0] ref_mem [MAX_LEN];
    logic [DATA_W-1:0] tgt_mem [MAX_LEN];
    logic [DATA_W-1:0] rd_ref_reg, rd_tgt_reg;

    logic [CNT_W-1:0]  cnt_reg, n_reg, idx_reg;
    logic              last_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [DATA_W-1:0] ip_reg;

    // serial multiplier
    logic [MAG_W-1:0]  mcand_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic [4:0]        step_reg;

    // square root and divider
    logic [SUMSQ_W-1:0] sumsq_reg, s_reg, res_reg, bit_reg;
    logic [LEN_W-1:0]   len_reg, rem_reg;
    logic [DIVD_W-1:0]  quo_reg;

    // output registers
    logic              valid_reg, last_out_reg, degen_reg;
    logic [DATA_W-1:0] result_reg;

    // combinational datapath
    logic [MAG_W:0]      mul_sum;
    logic [PROD_W-1:0]   mul_step;
    logic [PROD_W:0]     prod_s;
    logic [ACC_W-1:0]    acc_add, acc_mag, acc_rsum;
    logic [ACC_W-15:0]   acc_rnd;
    logic [DATA_W-1:0]   ip_val;
    logic [PROD_W-1:0]   p_rsum;
    logic [PROD_W-15:0]  p_rnd;
    logic [PROD_W-13:0]  rnd_s;
    logic [PROD_W-13:0]  resid;
    logic [DATA_W-1:0]   rs_val;
    logic [SUMSQ_W-1:0]  sumsq_add, sq_t;
    logic [LEN_W:0]      rem2, rem_sub;
    logic                rem_ge;
    logic [DATA_W-1:0]   q_val;
    logic                accept;
    logic                mem_we_load, mem_we_resid;
    logic [ADDR_W-1:0]   wr_addr;
    logic [DATA_W-1:0]   tgt_wdata;

    assign accept = start && (state_reg == S_IDLE);

    // multiplier step: add-and-shift on the high half
    assign mul_sum  = {1'b0, prod_reg[PROD_W-1:MAG_W]} +
                      (prod_reg[0] ? {1'b0, mcand_reg} : (MAG_W+1)'(0));
    assign mul_step = {mul_sum, prod_reg[MAG_W-1:1]};
    assign prod_s   = neg_reg ? (~{1'b0, prod_reg} + (PROD_W+1)'(1)) : {1'b0, prod_reg};
    assign acc_add  = acc_reg + {{(ACC_W-PROD_W-1){prod_s[PROD_W]}}, prod_s};

    // inner product rounding and saturation
    assign acc_mag  = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
    assign acc_rsum = acc_mag + ACC_W'(8192);
    assign acc_rnd  = acc_rsum[ACC_W-1:FRAC_W];
    always_comb
    begin
        if (!acc_reg[ACC_W-1])
            ip_val = (acc_rnd > (ACC_W-14)'(32767)) ? 16'h7fff : acc_rnd[DATA_W-1:0];
        else
            ip_val = (acc_rnd > (ACC_W-14)'(32768)) ? 16'h8000 : (~acc_rnd[DATA_W-1:0] + 16'd1);
    end

    // residual rounding, subtraction and saturation
    assign p_rsum = prod_reg + PROD_W'(8192);
    assign p_rnd  = p_rsum[PROD_W-1:FRAC_W];
    assign rnd_s  = neg_reg ? (~{2'b00, p_rnd} + (PROD_W-12)'(1)) : {2'b00, p_rnd};
    assign resid  = {{(PROD_W-12-DATA_W){rd_tgt_reg[DATA_W-1]}}, rd_tgt_reg} - rnd_s;
    always_comb
    begin
        if (!resid[PROD_W-13] && (resid[PROD_W-14:DATA_W-1] != '0))
            rs_val = 16'h7fff;
        else if (resid[PROD_W-13] && (resid[PROD_W-14:DATA_W-1] != '1))
            rs_val = 16'h8000;
        else
            rs_val = resid[DATA_W-1:0];
    end

    assign sumsq_add = sumsq_reg + SUMSQ_W'(prod_reg);
    assign sq_t      = res_reg + bit_reg;

    // restoring divider step
    assign rem2    = {rem_reg, quo_reg[DIVD_W-1]};
    assign rem_ge  = rem2 >= {1'b0, len_reg};
    assign rem_sub = rem2 - {1'b0, len_reg};

    // quotient saturation with the sign of the residual
    always_comb
    begin
        if (!rd_tgt_reg[DATA_W-1])
            q_val = (quo_reg >= DIVD_W'(32767)) ? 16'h7fff : quo_reg[DATA_W-1:0];
        else
            q_val = (quo_reg >= DIVD_W'(32768)) ? 16'h8000 : (~quo_reg[DATA_W-1:0] + 16'd1);
    end

    // store write port
    assign mem_we_load  = accept;
    assign mem_we_resid = (state_reg == S_RSUB);
    assign wr_addr      = mem_we_load ? cnt_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign tgt_wdata    = mem_we_load ? target_value : rs_val;

    always_ff @(posedge clk)
    begin
        if (mem_we_load)
            ref_mem[wr_addr] <= reference_value;
        if (mem_we_load || mem_we_resid)
            tgt_mem[wr_addr] <= tgt_wdata;
        rd_ref_reg <= ref_mem[idx_reg[ADDR_W-1:0]];
        rd_tgt_reg <= tgt_mem[idx_reg[ADDR_W-1:0]];
    end

    // control sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            acc_reg      <= '0;
            valid_reg    <= 1'b0;
            last_out_reg <= 1'b0;
            degen_reg    <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mcand_reg <= mag16(reference_value);
                        prod_reg  <= {{(PROD_W-MAG_W){1'b0}}, mag16(target_value)};
                        neg_reg   <= reference_value[DATA_W-1] ^ target_value[DATA_W-1];
                        last_reg  <= last_in || (cnt_reg == CNT_W'(MAX_LEN-1));
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        step_reg  <= 5'(MAG_W);
                        state_reg <= S_LMUL;
                    end
                end
                S_LMUL:
                begin
                    prod_reg <= mul_step;
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd1)
                        state_reg <= S_LACC;
                end
                S_LACC:
                begin
                    acc_reg <= acc_add;
                    if (last_reg)
                    begin
                        n_reg     <= cnt_reg;
                        state_reg <= S_IP;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_IP:
                begin
                    ip_reg    <= ip_val;
                    idx_reg   <= '0;
                    sumsq_reg <= '0;
                    state_reg <= S_RRD;
                end
                S_RRD:
                    state_reg <= S_RSET;
                S_RSET:
                begin
                    mcand_reg <= mag16(ip_reg);
                    prod_reg  <= {{(PROD_W-MAG_W){1'b0}}, mag16(rd_ref_reg)};
                    neg_reg   <= ip_reg[DATA_W-1] ^ rd_ref_reg[DATA_W-1];
                    step_reg  <= 5'(MAG_W);
                    state_reg <= S_RMUL1;
                end
                S_RMUL1, S_RMUL2:
                begin
                    prod_reg <= mul_step;
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd1)
                        state_reg <= (state_reg == S_RMUL1) ? S_RSUB : S_RACC;
                end
                S_RSUB:
                begin
                    mcand_reg <= mag16(rs_val);
                    prod_reg  <= {{(PROD_W-MAG_W){1'b0}}, mag16(rs_val)};
                    neg_reg   <= 1'b0;
                    step_reg  <= 5'(MAG_W);
                    state_reg <= S_RMUL2;
                end
                S_RACC:
                begin
                    sumsq_reg <= sumsq_add;
                    s_reg     <= sumsq_add;
                    res_reg   <= '0;
                    bit_reg   <= SUMSQ_W'(1) << (SUMSQ_W-1);
                    if (idx_reg == n_reg - CNT_W'(1))
                        state_reg <= S_SQRT;
                    else
                    begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_RRD;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        len_reg   <= res_reg[LEN_W-1:0];
                        idx_reg   <= '0;
                        state_reg <= S_DRD;
                    end
                    else
                    begin
                        if (s_reg >= sq_t)
                        begin
                            s_reg   <= s_reg - sq_t;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                            res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_DRD:
                    state_reg <= S_DSET;
                S_DSET:
                begin
                    quo_reg   <= {mag16(rd_tgt_reg), {FRAC_W{1'b0}}} +
                                 {{(DIVD_W-LEN_W+1){1'b0}}, len_reg[LEN_W-1:1]};
                    rem_reg   <= '0;
                    step_reg  <= 5'(DIVD_W);
                    state_reg <= (len_reg == '0) ? S_DOUT : S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_ge ? rem_sub[LEN_W-1:0] : rem2[LEN_W-1:0];
                    quo_reg  <= {quo_reg[DIVD_W-2:0], rem_ge};
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd1)
                        state_reg <= S_DOUT;
                end
                S_DOUT:
                begin
                    valid_reg    <= 1'b1;
                    result_reg   <= (len_reg == '0) ? '0 : q_val;
                    degen_reg    <= (len_reg == '0);
                    last_out_reg <= (idx_reg == n_reg - CNT_W'(1));
                    if (idx_reg == n_reg - CNT_W'(1))
                    begin
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_DRD;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign valid        = valid_reg;
    assign result_value = result_reg;
    assign last_out     = last_out_reg;
    assign degenerate   = degen_reg;

    // checks
    `ASSERT_SAME(a_valid_after_busy, valid, $past(busy))
    `ASSERT_SAME(a_degen_zero, valid && degenerate, result_value == '0)
    `ASSERT_NEXT(a_start_busy, start && !busy, busy)

endmodule
